FILE: hw/rtl/point_transform_4x4_unit_defines.svh
// assertion macros shared by the point transform rtl
`ifndef POINT_TRANSFORM_4X4_UNIT_DEFINES_SVH
`define POINT_TRANSFORM_4X4_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PTX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PTX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ptx_pkg.sv
// constants, codes and types of the point transform unit
`default_nettype none

package ptx_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int PORT_W      = 32;
	localparam int COEF_W      = 32;
	localparam int VEC_W       = COEF_W + 1;
	localparam int PROD_W      = COEF_W + VEC_W;
	localparam int SUM_W       = PROD_W + 3;
	localparam int RND_W       = SUM_W - FRAC_BITS;
	localparam int NUM_ELEMS   = 16;
	localparam int NUM_CFG     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_TERMS   = 3;
	localparam int NUM_LANES   = 3;

	// divider: quotient bits retired per stage
	localparam int DIV_STEP    = 2;
	localparam int QP_MIN      = CW + FRAC_BITS;
	localparam int DIV_STAGES  = (QP_MIN + DIV_STEP - 1) / DIV_STEP;
	localparam int QP          = DIV_STAGES * DIV_STEP;
	// s1, s2, s3, divider entry, divider stages, output register
	localparam int NSTG        = DIV_STAGES + 5;

	localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_CFG] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd65536, 64'd0, 64'd0, 64'd281474976710656
	};

	typedef enum logic [2:0] {
		CMD_DIR       = 3'd0,
		CMD_AFFINE    = 3'd1,
		CMD_PERSP     = 3'd2,
		CMD_INV_POINT = 3'd3,
		CMD_INV_DIR   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][QP-1:0] rq;
		logic [NUM_LANES-1:0][CW-1:0] rem;
		logic [CW-1:0]                dvs;
		logic [NUM_LANES-1:0]         neg;
		logic [NUM_LANES-1:0][CW-1:0] res;
		logic                         ok;
		logic                         persp;
	} div_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/point_transform_4x4_unit.sv
// top level: pipelined homogeneous 4x4 point transform with perspective divide
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------
//  in      | into unit | in_valid/in_stall   | cmd, in_x, in_y, in_z
//  out     | from unit | out_valid/out_stall | out_x, out_y, out_z, w_ok
//  cfg     | into unit | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word accepted per cycle while in_stall is low; the stages are operand
// select, 12 multipliers, row sum and round, then the 48-bit quotient retired
// two bits per stage in the divider lanes
// every word runs the full pipeline so results leave in order
// stalls hold only the full stages; bubbles below a stall still close up
// arst_n clears valid bits and loads the reset matrix (ones at elements 0, 5, 8
// and 15, zeros elsewhere); cfg_ready is always high
`default_nettype none
`include "point_transform_4x4_unit_defines.svh"

module point_transform_4x4_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [2:0]                          cmd,
	input  wire logic signed [ptx_pkg::PORT_W-1:0]   in_x,
	input  wire logic signed [ptx_pkg::PORT_W-1:0]   in_y,
	input  wire logic signed [ptx_pkg::PORT_W-1:0]   in_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [ptx_pkg::PORT_W-1:0]        out_x,
	output logic signed [ptx_pkg::PORT_W-1:0]        out_y,
	output logic signed [ptx_pkg::PORT_W-1:0]        out_z,
	output logic                                     w_ok,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ptx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ptx_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW     = ptx_pkg::CW;
	localparam int FRAC   = ptx_pkg::FRAC_BITS;
	localparam int COEF_W = ptx_pkg::COEF_W;
	localparam int VEC_W  = ptx_pkg::VEC_W;
	localparam int PROD_W = ptx_pkg::PROD_W;
	localparam int SUM_W  = ptx_pkg::SUM_W;
	localparam int RND_W  = ptx_pkg::RND_W;
	localparam int QP     = ptx_pkg::QP;
	localparam int DS     = ptx_pkg::DIV_STAGES;
	localparam int NSTG   = ptx_pkg::NSTG;
	localparam int NR     = ptx_pkg::NUM_ROWS;
	localparam int NT     = ptx_pkg::NUM_TERMS;
	localparam int NL     = ptx_pkg::NUM_LANES;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);
	localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) << (CW - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
	localparam logic [QP-1:0] Q_POS_LIM = (QP'(1) << (CW - 1)) - QP'(1);
	localparam logic [QP-1:0] Q_NEG_LIM = QP'(1) << (CW - 1);

	// configuration: eight coefficient pairs
	logic [ptx_pkg::CFG_DATA_W-1:0] cfg_q [ptx_pkg::NUM_CFG];
	logic signed [COEF_W-1:0] elem [ptx_pkg::NUM_ELEMS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ptx_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// column-major: element k sits in pair k/2, low half for even k
	always_comb begin
		for (int k = 0; k < ptx_pkg::NUM_ELEMS; k++) begin
			elem[k] = $signed(cfg_q[k >> 1][(k & 1) * COEF_W +: COEF_W]);
		end
	end

	// pipeline flow control: a stage may load unless it and all below are full
	logic [NSTG-1:0] vld;
	logic [NSTG-1:0] en;

	always_comb begin
		for (int k = 0; k < NSTG; k++) begin
			en[k] = !out_stall ||
				((vld | ((NSTG'(1) << k) - NSTG'(1))) != {NSTG{1'b1}});
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// stage 0: operand selection per mode
	logic signed [VEC_W-1:0]  vin [NT];
	logic signed [COEF_W-1:0] a_d [NR][NT];
	logic signed [VEC_W-1:0]  b_d [NR][NT];
	logic signed [COEF_W-1:0] t_d [NR];
	logic                     persp_d;
	logic                     okc_d;

	always_comb begin
		vin[0] = VEC_W'($signed(in_x[CW-1:0]));
		vin[1] = VEC_W'($signed(in_y[CW-1:0]));
		vin[2] = VEC_W'($signed(in_z[CW-1:0]));
		for (int r = 0; r < NR; r++) begin
			t_d[r] = '0;
			for (int j = 0; j < NT; j++) begin
				a_d[r][j] = '0;
				b_d[r][j] = '0;
			end
		end
		persp_d = 1'b0;
		okc_d   = 1'b1;
		case (ptx_pkg::cmd_t'(cmd))
			ptx_pkg::CMD_DIR, ptx_pkg::CMD_AFFINE, ptx_pkg::CMD_PERSP: begin
				persp_d = (ptx_pkg::cmd_t'(cmd) == ptx_pkg::CMD_PERSP);
				for (int r = 0; r < NR; r++) begin
					for (int j = 0; j < NT; j++) begin
						a_d[r][j] = elem[r + 4 * j];
						b_d[r][j] = vin[j];
					end
					if (ptx_pkg::cmd_t'(cmd) != ptx_pkg::CMD_DIR) begin
						t_d[r] = elem[12 + r];
					end
				end
			end
			ptx_pkg::CMD_INV_POINT, ptx_pkg::CMD_INV_DIR: begin
				// transposed rotation applied to the point, less translation for CMD_INV_POINT
				for (int r = 0; r < NT; r++) begin
					for (int j = 0; j < NT; j++) begin
						a_d[r][j] = elem[4 * r + j];
						if (ptx_pkg::cmd_t'(cmd) == ptx_pkg::CMD_INV_POINT) begin
							b_d[r][j] = vin[j] - VEC_W'(elem[12 + j]);
						end else begin
							b_d[r][j] = vin[j];
						end
					end
				end
			end
			default: begin
				okc_d = 1'b0;
			end
		endcase
	end

	logic signed [COEF_W-1:0] a_s1 [NR][NT];
	logic signed [VEC_W-1:0]  b_s1 [NR][NT];
	logic signed [COEF_W-1:0] t_s1 [NR];
	logic                     persp_s1;
	logic                     okc_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1     <= a_d;
			b_s1     <= b_d;
			t_s1     <= t_d;
			persp_s1 <= persp_d;
			okc_s1   <= okc_d;
		end
	end

	// stage 2: twelve exact products
	logic signed [PROD_W-1:0] p_s2 [NR][NT];
	logic signed [COEF_W-1:0] t_s2 [NR];
	logic                     persp_s2;
	logic                     okc_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < NR; r++) begin
				for (int j = 0; j < NT; j++) begin
					p_s2[r][j] <= a_s1[r][j] * b_s1[r][j];
				end
			end
			t_s2     <= t_s1;
			persp_s2 <= persp_s1;
			okc_s2   <= okc_s1;
		end
	end

	// stage 3: row sums, round half up to coordinate scale
	logic signed [SUM_W-1:0] sum_d [NR];
	logic signed [RND_W-1:0] rnd_s3 [NR];
	logic                    persp_s3;
	logic                    okc_s3;

	always_comb begin
		for (int r = 0; r < NR; r++) begin
			sum_d[r] = SUM_W'(p_s2[r][0]) + SUM_W'(p_s2[r][1]) + SUM_W'(p_s2[r][2])
				+ (SUM_W'(t_s2[r]) <<< FRAC) + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int r = 0; r < NR; r++) begin
				rnd_s3[r] <= RND_W'(sum_d[r] >>> FRAC);
			end
			persp_s3 <= persp_s2;
			okc_s3   <= okc_s2;
		end
	end

	function automatic logic signed [CW-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
		if (v > SAT_HI) begin
			return {1'b0, {(CW - 1){1'b1}}};
		end else if (v < SAT_LO) begin
			return {1'b1, {(CW - 1){1'b0}}};
		end
		return v[CW-1:0];
	endfunction

	// divider entry: saturate rows, split sign and magnitude
	logic signed [CW-1:0] satv [NR];
	logic [CW-1:0]        mag  [NR];
	ptx_pkg::div_word_t   div_d;

	always_comb begin
		for (int r = 0; r < NR; r++) begin
			satv[r] = sat_rnd(rnd_s3[r]);
			mag[r]  = satv[r][CW-1] ? CW'(-satv[r]) : satv[r];
		end
		div_d.dvs   = mag[3];
		div_d.persp = persp_s3;
		// zero w in perspective mode clears the word
		div_d.ok    = okc_s3 && !(persp_s3 && (satv[3] == '0));
		for (int l = 0; l < NL; l++) begin
			div_d.rq[l]  = QP'(mag[l]) << FRAC;
			div_d.rem[l] = '0;
			div_d.neg[l] = satv[l][CW-1] ^ satv[3][CW-1];
			div_d.res[l] = satv[l];
		end
	end

	function automatic ptx_pkg::div_word_t div_step(input ptx_pkg::div_word_t d);
		ptx_pkg::div_word_t n;
		logic [CW:0]        trial;
		logic               qb;
		n = d;
		for (int l = 0; l < NL; l++) begin
			for (int s = 0; s < ptx_pkg::DIV_STEP; s++) begin
				trial = {n.rem[l], n.rq[l][QP-1]};
				qb = (trial >= {1'b0, n.dvs});
				n.rem[l] = qb ? CW'(trial - {1'b0, n.dvs}) : trial[CW-1:0];
				n.rq[l] = {n.rq[l][QP-2:0], qb};
			end
		end
		return n;
	endfunction

	// restoring divider lanes; the dividend shifts out as quotient bits shift in
	ptx_pkg::div_word_t div_s [DS + 1];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			div_s[0] <= div_d;
		end
		for (int k = 1; k <= DS; k++) begin
			if (en[3 + k]) begin
				div_s[k] <= div_step(div_s[k-1]);
			end
		end
	end

	// output stage: sign, saturation and mode select
	logic [QP-1:0]        quo [NL];
	logic signed [CW-1:0] res_d [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			quo[l] = div_s[DS].rq[l];
			if (!div_s[DS].ok) begin
				res_d[l] = '0;
			end else if (!div_s[DS].persp) begin
				res_d[l] = div_s[DS].res[l];
			end else if (!div_s[DS].neg[l]) begin
				res_d[l] = (quo[l] > Q_POS_LIM) ? {1'b0, {(CW - 1){1'b1}}} : quo[l][CW-1:0];
			end else begin
				res_d[l] = (quo[l] > Q_NEG_LIM) ? {1'b1, {(CW - 1){1'b0}}}
					: CW'(-quo[l][CW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			out_x <= ptx_pkg::PORT_W'(res_d[0]);
			out_y <= ptx_pkg::PORT_W'(res_d[1]);
			out_z <= ptx_pkg::PORT_W'(res_d[2]);
			w_ok  <= div_s[DS].ok;
		end
	end

	// a blocked input means every stage is full and the output is stalled
	`PTX_ASSERT_NOW(a_stall_full, in_stall, (&vld) && out_stall, "input stalled with a free stage")
	// a word held in stage one while stage two is blocked stays there
	`PTX_ASSERT_NEXT(a_s1_hold, vld[0] && !en[1], vld[0], "word lost from stage one")
	// partial remainders of lanes 0 and 2 stay below the divisor
	`PTX_ASSERT_NOW(a_div_rem, vld[NSTG-2] && div_s[DS].persp && (div_s[DS].dvs != '0), (div_s[DS].rem[0] < div_s[DS].dvs) && (div_s[DS].rem[2] < div_s[DS].dvs), "divider remainder out of range")
	// a rejected word leaves with zero coordinates
	`PTX_ASSERT_NOW(a_zero_bad, out_valid && !w_ok, (out_x == '0) && (out_y == '0) && (out_z == '0), "invalid word with nonzero result")

endmodule

`default_nettype wire
